[rtl/pcmppt_pkg.sv]
// ----------------------------------------------------------------------------
// pcmppt_pkg
// Shared types and constants of the PCM position and period tracker: request
// and result payloads, register indexes, operation codes and the interface of
// the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmppt_pkg;

    // Operation codes of an input request
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_RSVD    = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FRAMES = 2'd2;

    // Register reset values
    localparam logic [15:0] SAMPLE_RATE_RESET   = 16'd48000;
    localparam logic [16:0] BUFFER_FRAMES_RESET = 17'd4096;
    localparam logic [15:0] PERIOD_FRAMES_RESET = 16'd1024;

    // Default block parameters
    localparam int unsigned TICKS_PER_SECOND_DEF  = 1000;
    localparam int unsigned MAX_BUFFER_FRAMES_DEF = 65536;

    localparam logic [9:0] PENDING_MAX = 10'd1023;

    // Shared divider widths
    localparam int unsigned DIV_NUM_W = 33;
    localparam int unsigned DIV_DEN_W = 32;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] delta_ticks;
    } in_item_t;

    typedef struct packed {
        logic [15:0] position_frames;
        logic [9:0]  periods_elapsed;
        logic [15:0] next_timeout_ticks;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
        logic [DIV_DEN_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

[rtl/pcmppt_div.sv]
// ----------------------------------------------------------------------------
// pcmppt_div
// Shared restoring divider: one quotient bit per cycle; done pulses for one
// cycle with quotient and remainder valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmppt_div
    import pcmppt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int unsigned CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_NUM_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W+1:0] diff;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = ~diff[DIV_DEN_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // subtract where the divisor fits, shift in the quotient bit
            rem_next = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

[rtl/pcm_position_period_tracker.sv]
// ----------------------------------------------------------------------------
// pcm_position_period_tracker
// Virtual ring buffer play position and period tracker, sequenced around one
// shared bit-serial divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | input     | in_valid / in_stall | in_item_t (op, delta_ticks)
//  out     | output    | out_valid/out_stall | out_item_t (position, periods,
//          |           |                     |   timeout)
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
//  One request at a time: three divisions (position wrap, period split,
//  timeout) plus single steps; no boundary crossed skips the split, zero
//  delta, restart or the unused op also skip the wrap, a zero buffer skips
//  only the wrap and a zero rate skips the timeout division.
//  Reset clears the state at once; there is no clearing pass.
//  in_stall is high from acceptance until the result is loaded into the
//  output register; a stalled output holds its result and the next request
//  is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_position_period_tracker
    import pcmppt_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND  = TICKS_PER_SECOND_DEF,
    parameter int unsigned MAX_BUFFER_FRAMES = MAX_BUFFER_FRAMES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Scaled constants: ticks per second, buffer cap and reset remainder
    localparam logic [31:0] TPS_C        = 32'(TICKS_PER_SECOND);
    localparam logic [16:0] MAX_BUF_C    = 17'(MAX_BUFFER_FRAMES);
    localparam logic [31:0] REM_RESET_C  = 32'(int'(PERIOD_FRAMES_RESET) * TICKS_PER_SECOND);

    // Frame position by reciprocal multiply: the scaled position stays below
    // 2^POS_W, and a reciprocal rounded up with this shift is exact there
    localparam int unsigned POS_W       = 26;
    localparam int unsigned FRAME_SHIFT = POS_W + $clog2(TICKS_PER_SECOND);
    localparam logic [63:0] FRAME_RECIP_W =
        ((64'd1 << FRAME_SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
    localparam logic [POS_W+1:0] FRAME_RECIP_C = FRAME_RECIP_W[POS_W+1:0];

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_MODW = 4'd3;
    localparam logic [3:0] S_PER  = 4'd4;
    localparam logic [3:0] S_PERW = 4'd5;
    localparam logic [3:0] S_POS  = 4'd6;
    localparam logic [3:0] S_TMO  = 4'd8;
    localparam logic [3:0] S_TMOW = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]  state_reg, state_next;

    // Configuration registers
    logic [15:0] rate_reg, rate_next;
    logic [16:0] buf_reg, buf_next;
    logic [15:0] period_reg, period_next;

    // Tracker state
    logic [31:0] pos_reg, pos_next;
    logic [31:0] rem_reg, rem_next;
    logic [9:0]  pend_reg, pend_next;

    // Request working registers
    logic [1:0]  op_reg, op_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] fbs_reg, fbs_next;
    logic [31:0] fps_reg, fps_next;
    logic [15:0] frame_reg, frame_next;
    logic [15:0] tmo_reg, tmo_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic [16:0] buf_eff;
    logic [15:0] period_eff;
    logic [10:0] pend_sum;
    logic        pend_sat;
    logic        out_free;
    logic [2*POS_W+1:0] frame_prod;

    pcmppt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Clamp the buffer size, treat a zero period as one frame
    assign buf_eff    = (buf_reg > MAX_BUF_C) ? MAX_BUF_C : buf_reg;
    assign period_eff = (period_reg == 16'd0) ? 16'd1 : period_reg;

    // Saturating add of the crossed periods into the pending count
    assign pend_sum = {1'b0, pend_reg} + {1'b0, div_rsp.quotient[9:0]};
    assign pend_sat = (|div_rsp.quotient[DIV_NUM_W-1:10]) || pend_sum[10];

    // Scaled position times the reciprocal of the ticks per second
    assign frame_prod = {{(POS_W+2){1'b0}}, pos_reg[POS_W-1:0]}
                      * {{POS_W{1'b0}}, FRAME_RECIP_C};

    // Output register can take a new result
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration writes
    always_comb
    begin
        rate_next   = rate_reg;
        buf_next    = buf_reg;
        period_next = period_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_RATE:   rate_next   = cfg_data[15:0];
                CFG_BUFFER_FRAMES: buf_next    = cfg_data;
                CFG_PERIOD_FRAMES: period_next = cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        op_next        = op_reg;
        ticks_next     = ticks_reg;
        d_next         = d_reg;
        fbs_next       = fbs_reg;
        fps_next       = fps_reg;
        frame_next     = frame_reg;
        tmo_next       = tmo_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // take the next request
                if (in_valid)
                begin
                    op_next    = in_data.op;
                    ticks_next = in_data.delta_ticks;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // advance amount and scaled buffer and period sizes
                d_next   = 32'(ticks_reg) * 32'(rate_reg);
                fbs_next = 32'(buf_eff) * TPS_C;
                fps_next = 32'(period_eff) * TPS_C;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (op_reg == OP_RESTART)
                begin
                    pos_next   = '0;
                    rem_next   = fps_reg;
                    pend_next  = '0;
                    state_next = S_POS;
                end
                else if (op_reg == OP_RSVD || ticks_reg == 16'd0)
                begin
                    // no advance
                    state_next = S_POS;
                end
                else if (fbs_reg == 32'd0)
                begin
                    // zero buffer: hold the position at zero
                    pos_next   = '0;
                    state_next = S_PER;
                end
                else
                begin
                    // wrap the advanced position into the buffer
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, pos_reg} + {1'b0, d_reg};
                    div_req.divisor  = fbs_reg;
                    state_next       = S_MODW;
                end
            end
            S_MODW:
            begin
                if (div_rsp.done)
                begin
                    pos_next   = div_rsp.remainder;
                    state_next = S_PER;
                end
            end
            S_PER:
            begin
                if (rem_reg > d_reg)
                begin
                    rem_next   = rem_reg - d_reg;
                    state_next = S_POS;
                end
                else
                begin
                    // split the overshoot into whole periods and a remainder
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, d_reg - rem_reg};
                    div_req.divisor  = fps_reg;
                    state_next       = S_PERW;
                end
            end
            S_PERW:
            begin
                if (div_rsp.done)
                begin
                    // one more period than whole periods in the overshoot
                    rem_next   = fps_reg - div_rsp.remainder;
                    pend_next  = (pend_sat || pend_sum[9:0] == PENDING_MAX)
                               ? PENDING_MAX : pend_sum[9:0] + 10'd1;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                // whole frames of the scaled position
                frame_next = frame_prod[FRAME_SHIFT +: 16];
                state_next = S_TMO;
            end
            S_TMO:
            begin
                if (rate_reg == 16'd0)
                begin
                    tmo_next   = 16'hFFFF;
                    state_next = S_DONE;
                end
                else
                begin
                    // rounded-up ticks to the next boundary
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, rem_reg} + {17'd0, rate_reg} - 33'd1;
                    div_req.divisor  = {16'd0, rate_reg};
                    state_next       = S_TMOW;
                end
            end
            S_TMOW:
            begin
                if (div_rsp.done)
                begin
                    tmo_next   = (|div_rsp.quotient[DIV_NUM_W-1:16])
                               ? 16'hFFFF : div_rsp.quotient[15:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // load the result once the output register is free
                if (out_free)
                begin
                    out_valid_next                   = 1'b1;
                    out_data_next.position_frames    = frame_reg;
                    out_data_next.periods_elapsed    = pend_reg;
                    out_data_next.next_timeout_ticks = tmo_reg;
                    if (op_reg == OP_TICK)
                    begin
                        pend_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= SAMPLE_RATE_RESET;
            buf_reg       <= BUFFER_FRAMES_RESET;
            period_reg    <= PERIOD_FRAMES_RESET;
            pos_reg       <= '0;
            rem_reg       <= REM_RESET_C;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            buf_reg       <= buf_next;
            period_reg    <= period_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ticks_reg    <= ticks_next;
        d_reg        <= d_next;
        fbs_reg      <= fbs_next;
        fps_reg      <= fps_next;
        frame_reg    <= frame_next;
        tmo_reg      <= tmo_next;
        out_data_reg <= out_data_next;
    end

    // An accepted request always starts the sequencer
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MUL))
        else $error("accepted request did not start the sequencer");

    // The divider is never restarted while a division runs
    a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A new result only comes from the final sequencer step
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("output loaded outside the final step");

    // A division result is only awaited in a wait state
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_MODW || state_reg == S_PERW
                          || state_reg == S_TMOW))
        else $error("division finished outside a wait state");

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - PCM position and period tracker testbench
// Drives requests and register writes into the tracker and checks every
// result against a hand-computed value or a cycle-free model of the ring
// buffer position, the period remainder and the saturating period count.
// A directed table comes first. Random phases with varied register settings
// follow, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import pcmppt_pkg::*;

    localparam logic [63:0] TICKS = TICKS_PER_SECOND_DEF;
    localparam logic [63:0] MAX_FRAMES = MAX_BUFFER_FRAMES_DEF;
    // The port allows a fourth register index, which the block ignores
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned HOLD_CYCLES = 3000;
    localparam int unsigned PHASES = 14;
    localparam int unsigned PHASE_ITEMS = 125;

    // One row of the directed table: a register write or a request, with an
    // optional hand-computed result
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [1:0]            op;
        logic [15:0]           delta;
        logic                  typed;
        out_item_t             want;
    } step_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b1;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow registers and tracker state
    logic [15:0] shadow_rate;
    logic [16:0] shadow_buffer;
    logic [15:0] shadow_period;
    logic [31:0] play_pos;
    logic [31:0] to_boundary;
    logic [9:0]  periods_owed;

    out_item_t   due_reports[$];
    step_row_t   plan[$];
    int unsigned faults = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;
    bit          hold_arm = 1'b0;
    bit          hold_spent;
    int unsigned hold_left;

    pcm_position_period_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Advance the tracker by one request and return the report it produces
    function automatic out_item_t track_request(input in_item_t req);
        logic [63:0] rate;
        logic [63:0] step;
        logic [63:0] ring;
        logic [63:0] span;
        logic [63:0] rest;
        logic [63:0] crossed;
        logic [63:0] total;
        logic [63:0] wait_ticks;
        logic [9:0]  reported;
        out_item_t   rpt;
        rate = {48'd0, shadow_rate};
        span = ((shadow_period == 16'd0) ? 64'd1 : {48'd0, shadow_period}) * TICKS;
        if (req.op == OP_RESTART) begin
            play_pos = 32'd0;
            to_boundary = span[31:0];
            periods_owed = 10'd0;
        end
        else if (req.op != OP_RSVD && req.delta_ticks != 16'd0) begin
            step = {48'd0, req.delta_ticks} * rate;
            // Clamp an oversized ring; a zero-size ring pins the position
            ring = (({47'd0, shadow_buffer} > MAX_FRAMES) ? MAX_FRAMES
                    : {47'd0, shadow_buffer}) * TICKS;
            if (ring == 64'd0)
                play_pos = 32'd0;
            else
            begin
                total = ({32'd0, play_pos} + step) % ring;
                play_pos = total[31:0];
            end
            rest = {32'd0, to_boundary};
            if (rest > step)
                rest = rest - step;
            else
            begin
                // Count every boundary crossed and refill the remainder
                crossed = (step - rest) / span + 64'd1;
                rest = rest + crossed * span - step;
                total = {54'd0, periods_owed} + crossed;
                periods_owed = (total > {54'd0, PENDING_MAX}) ? PENDING_MAX : total[9:0];
            end
            to_boundary = rest[31:0];
        end
        reported = periods_owed;
        if (req.op == OP_TICK)
            periods_owed = 10'd0;
        total = {32'd0, play_pos} / TICKS;
        rpt.position_frames = total[15:0];
        rpt.periods_elapsed = reported;
        if (rate == 64'd0)
            rpt.next_timeout_ticks = 16'hFFFF;
        else
        begin
            wait_ticks = ({32'd0, to_boundary} + rate - 64'd1) / rate;
            rpt.next_timeout_ticks = (wait_ticks > 64'hFFFF) ? 16'hFFFF : wait_ticks[15:0];
        end
        return rpt;
    endfunction

    function automatic step_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        step_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic step_row_t item_row(input logic [1:0] op, input logic [15:0] ticks);
        step_row_t r;
        r = '0;
        r.op = op;
        r.delta = ticks;
        return r;
    endfunction

    function automatic step_row_t known_row(input logic [1:0] op, input logic [15:0] ticks,
                                            input logic [15:0] pos, input logic [9:0] owed,
                                            input logic [15:0] wait_ticks);
        step_row_t r;
        r = item_row(op, ticks);
        r.typed = 1'b1;
        r.want.position_frames = pos;
        r.want.periods_elapsed = owed;
        r.want.next_timeout_ticks = wait_ticks;
        return r;
    endfunction

    // Offer one request, hold it until taken, then queue its expected report.
    // Valid stays high into the next request unless an idle cycle is drawn.
    task automatic offer_request(input logic [1:0] op, input logic [15:0] ticks,
                                 input logic typed, input out_item_t want);
        in_item_t  req;
        out_item_t rpt;
        req.op = op;
        req.delta_ticks = ticks;
        while (!steady && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        cfg_write <= 1'b0;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rpt = track_request(req);
        due_reports.push_back(typed ? want : rpt);
    endtask

    // Drop valid and wait until every queued report has come back
    task automatic await_quiet();
        in_valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; the enable is dropped by the next request
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_SAMPLE_RATE:   shadow_rate = val[15:0];
            CFG_BUFFER_FRAMES: shadow_buffer = val;
            CFG_PERIOD_FRAMES: shadow_period = val[15:0];
            default: ;
        endcase
    endtask

    // Output side: random stall, plus one long hold-off when armed so the
    // block fills up and pushes back on the request channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_spent <= 1'b0;
        end
        else if (hold_arm && !hold_spent)
        begin
            hold_left <= HOLD_CYCLES;
            hold_spent <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !steady && ($urandom_range(99) < 12);
    end

    // Compare each delivered report with the oldest one expected
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_reports.size() == 0)
            begin
                faults = faults + 1;
                if (faults <= 10)
                    $display("unexpected report pos=%0d periods=%0d timeout=%0d",
                             out_data.position_frames, out_data.periods_elapsed,
                             out_data.next_timeout_ticks);
            end
            else
            begin
                if (out_data.position_frames !== due_reports[0].position_frames ||
                    out_data.periods_elapsed !== due_reports[0].periods_elapsed ||
                    out_data.next_timeout_ticks !== due_reports[0].next_timeout_ticks)
                begin
                    faults = faults + 1;
                    if (faults <= 10)
                        $display("mismatch exp pos=%0d periods=%0d timeout=%0d, %s%0d %0d %0d",
                                 due_reports[0].position_frames,
                                 due_reports[0].periods_elapsed,
                                 due_reports[0].next_timeout_ticks, "got ",
                                 out_data.position_frames, out_data.periods_elapsed,
                                 out_data.next_timeout_ticks);
                end
                void'(due_reports.pop_front());
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned k;
        int unsigned pick;
        logic [1:0]  op;
        logic [15:0] ticks;
        logic [CFG_DATA_W-1:0] val;

        // Hold every input at a known value through reset
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;

        shadow_rate = SAMPLE_RATE_RESET;
        shadow_buffer = BUFFER_FRAMES_RESET;
        shadow_period = PERIOD_FRAMES_RESET;
        play_pos = 32'd0;
        to_boundary = 32'(PERIOD_FRAMES_RESET * TICKS);
        periods_owed = 10'd0;

        plan = '{
            // Reset state, then a one-tick step
            known_row(OP_QUERY, 16'd0, 16'd0, 10'd0, 16'd22),
            known_row(OP_TICK, 16'd1, 16'd48, 10'd0, 16'd21),
            // Longest step wraps the ring exactly and saturates the count
            known_row(OP_TICK, 16'hFFFF, 16'd0, 10'd1023, 16'd22),
            known_row(OP_RESTART, 16'hFFFF, 16'd0, 10'd0, 16'd22),
            item_row(OP_QUERY, 16'd100),
            // Unused op with periods owed: reports like a query, changes nothing
            item_row(OP_RSVD, 16'hFFFF),
            item_row(OP_TICK, 16'd0),
            item_row(OP_QUERY, 16'h5AA5),
            // Zero rate: nothing moves, timeout pegs high
            write_row(CFG_SAMPLE_RATE, 17'd0),
            known_row(OP_RESTART, 16'd0, 16'd0, 10'd0, 16'hFFFF),
            known_row(OP_TICK, 16'd1000, 16'd0, 10'd0, 16'hFFFF),
            // Slowest rate with the longest period: timeout saturates
            write_row(CFG_SAMPLE_RATE, 17'd1),
            write_row(CFG_PERIOD_FRAMES, 17'd32768),
            known_row(OP_RESTART, 16'd0, 16'd0, 10'd0, 16'hFFFF),
            item_row(OP_TICK, 16'hFFFF),
            // Top data bit dropped from the rate; zero-size ring
            write_row(CFG_SAMPLE_RATE, 17'h1FFFF),
            write_row(CFG_BUFFER_FRAMES, 17'd0),
            item_row(OP_TICK, 16'hFFFF),
            item_row(OP_QUERY, 16'd12345),
            // Oversized ring clamps to the maximum
            write_row(CFG_BUFFER_FRAMES, 17'h1FFFF),
            item_row(OP_TICK, 16'hFFFF),
            item_row(OP_TICK, 16'd777),
            // Zero period acts as one frame; old remainder stays until restart
            write_row(CFG_PERIOD_FRAMES, 17'd0),
            item_row(OP_TICK, 16'd3000),
            item_row(OP_RESTART, 16'd0),
            item_row(OP_TICK, 16'd1),
            write_row(CFG_UNUSED, 17'h1FFFF),
            item_row(OP_QUERY, 16'd0),
            // Low corners of all registers
            write_row(CFG_SAMPLE_RATE, 17'd8000),
            write_row(CFG_BUFFER_FRAMES, 17'd2),
            write_row(CFG_PERIOD_FRAMES, 17'd1),
            item_row(OP_RESTART, 16'd0),
            item_row(OP_TICK, 16'd1),
            item_row(OP_TICK, 16'hFFFF),
            // High corners of all registers
            write_row(CFG_SAMPLE_RATE, 17'd48000),
            write_row(CFG_BUFFER_FRAMES, 17'd65536),
            write_row(CFG_PERIOD_FRAMES, 17'd32768),
            item_row(OP_TICK, 16'hFFFF),
            item_row(OP_QUERY, 16'd1),
            item_row(OP_RESTART, 16'd0)
        };

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                await_quiet();
                program_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                offer_request(plan[i].op, plan[i].delta, plan[i].typed, plan[i].want);
        end

        // Random phases, each under a fresh register setting
        for (phase = 0; phase < PHASES; phase++)
        begin
            await_quiet();
            case ($urandom_range(5))
                0: val = 17'd8000;
                1: val = 17'd48000;
                2: val = 17'($urandom_range(17'h1FFFF));
                3: val = 17'($urandom_range(1, 100));
                default: val = 17'($urandom_range(8000, 48000));
            endcase
            program_reg(CFG_SAMPLE_RATE, val);
            case ($urandom_range(6))
                0: val = 17'd2;
                1: val = 17'd65536;
                2: val = 17'($urandom_range(17'h1FFFF));
                3: val = 17'd0;
                default: val = 17'($urandom_range(2, 65536));
            endcase
            program_reg(CFG_BUFFER_FRAMES, val);
            case ($urandom_range(5))
                0: val = 17'd1;
                1: val = 17'd32768;
                2: val = 17'($urandom_range(17'h1FFFF));
                default: val = 17'($urandom_range(1, 32768));
            endcase
            program_reg(CFG_PERIOD_FRAMES, val);
            if ($urandom_range(3) == 0)
                program_reg(CFG_UNUSED, 17'($urandom_range(17'h1FFFF)));

            steady = (phase == 6);
            if (phase == 3)
                hold_arm = 1'b1;

            // Start clean half the time; otherwise run on the stale state
            if ($urandom_range(1) == 0)
                offer_request(OP_RESTART, 16'($urandom), 1'b0, '0);

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(99);
                op = (pick < 55) ? OP_TICK : (pick < 85) ? OP_QUERY :
                     (pick < 95) ? OP_RESTART : OP_RSVD;
                case ($urandom_range(9))
                    0: ticks = 16'd0;
                    1: ticks = 16'hFFFF;
                    2, 3: ticks = 16'($urandom);
                    default: ticks = 16'($urandom_range(1, 400));
                endcase
                offer_request(op, ticks, 1'b0, '0);
            end
        end
        steady = 1'b0;

        // Drain, then give a late or extra report time to show up
        await_quiet();
        repeat (300)
            @(posedge clk);
        if (faults == 0 && due_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
